/* hdl/pffl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pffl_pkg
// Shared types and codes for the page frame free list: command and status
// codes, field widths and the request / response word layouts.
// ----------------------------------------------------------------------------
package pffl_pkg;

   // field widths
   localparam int CMD_W    = 2;
   localparam int FRAME_W  = 10;
   localparam int STATUS_W = 2;
   localparam int FREE_W   = 11;

   // default pool size
   localparam int NUM_FRAMES_DEF = 1024;

   // command codes
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLAIM   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_WRONG = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [FRAME_W-1:0] frame_index;
   } req_word_type;

   typedef struct packed {
      logic [FRAME_W-1:0]  granted_frame;
      logic [STATUS_W-1:0] status;
      logic [FREE_W-1:0]   free_frames;
   } rsp_word_type;

endpackage
`default_nettype wire

/* hdl/pffl_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pffl_req_if
// Command channel: valid / ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface pffl_req_if import pffl_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/pffl_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pffl_rsp_if
// Response channel: valid / ready handshake carrying one response word.
// ----------------------------------------------------------------------------
interface pffl_rsp_if import pffl_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/page_frame_free_list.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_free_list
// LIFO free list of page frames kept as a doubly linked list in two link
// memories plus a free-flag memory; release pushes, allocate pops, claim
// unlinks a named free frame.
// ----------------------------------------------------------------------------
//  channel    dir   word fields                              handshake
//  req_chan   in    cmd, frame_index                         valid / ready
//  rsp_chan   out   granted_frame, status, free_frames       valid / ready
//
//  Each command first reads the link and flag memories at the accepted
//  word, then writes back the neighbor links and flag.
//  After reset the free-flag memory is swept to zero, one entry a cycle,
//  over all NUM_FRAMES entries; req_chan.ready stays low during the sweep.
//  A word is accepted while the previous response still waits; the
//  write-back cycle stalls only while the response register is full.
// ----------------------------------------------------------------------------
module page_frame_free_list
   import pffl_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pffl_req_if.sink  req_chan,
   pffl_rsp_if.source rsp_chan
);

   localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int LW = $clog2(NUM_FRAMES + 1);
   localparam logic [LW-1:0] NULL_LINK  = LW'(NUM_FRAMES);
   localparam logic [AW-1:0] LAST_FRAME = AW'(NUM_FRAMES - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // memories
   logic [LW-1:0] next_mem [NUM_FRAMES];
   logic [LW-1:0] prev_mem [NUM_FRAMES];
   logic          free_mem [NUM_FRAMES];

   // control and payload registers
   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [FRAME_W-1:0] idx_ff, idx_in;
   logic               idx_ok_ff, idx_ok_in;
   logic [LW-1:0]      head_ff, head_in;
   logic [FREE_W-1:0]  count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_data_ff, rsp_data_in;

   // registered memory read data
   logic               free_rd_ff;
   logic [LW-1:0]      next_rd_ff;
   logic [LW-1:0]      prev_rd_ff;

   // handshake
   logic accept;
   logic commit;
   logic [AW-1:0] req_addr;
   logic [AW-1:0] head_addr;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign commit         = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_addr       = AW'(req_chan.data.frame_index);
   assign head_addr      = AW'(head_ff);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // read port: issued once, at the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         free_rd_ff <= free_mem[req_addr];
         prev_rd_ff <= prev_mem[req_addr];
         next_rd_ff <= next_mem[(req_chan.data.cmd == CMD_ALLOC) ? head_addr : req_addr];
      end
   end

   // write-back decode
   logic               head_ok, n_ok, p_ok;
   logic [LW-1:0]      idx_link, p_val, n_val;
   logic [AW-1:0]      idx_addr;
   logic               fw_en, nw_en, pw_en;
   logic [AW-1:0]      fw_addr, nw_addr, pw_addr;
   logic               fw_data;
   logic [LW-1:0]      nw_data, pw_data;
   logic [LW-1:0]      new_head;
   logic [FREE_W-1:0]  new_count;
   logic [FRAME_W-1:0] granted;
   logic [STATUS_W-1:0] status;

   assign head_ok  = head_ff < NULL_LINK;
   assign n_ok     = next_rd_ff < NULL_LINK;
   assign idx_link = LW'(idx_ff);
   assign idx_addr = AW'(idx_ff);
   // the head's own back link is not written when a frame is released: read it as null
   assign p_val    = (idx_link == head_ff) ? NULL_LINK : prev_rd_ff;
   assign p_ok     = p_val < NULL_LINK;
   assign n_val    = n_ok ? next_rd_ff : NULL_LINK;

   always_comb begin
      fw_en     = 1'b0;
      nw_en     = 1'b0;
      pw_en     = 1'b0;
      fw_addr   = idx_addr;
      nw_addr   = idx_addr;
      pw_addr   = idx_addr;
      fw_data   = 1'b0;
      nw_data   = NULL_LINK;
      pw_data   = NULL_LINK;
      new_head  = head_ff;
      new_count = count_ff;
      granted   = idx_ff;
      status    = ST_WRONG;
      case (cmd_ff)
         CMD_RELEASE: begin
            if (idx_ok_ff && !free_rd_ff) begin
               status    = ST_OK;
               fw_en     = 1'b1;
               fw_data   = 1'b1;
               nw_en     = 1'b1;
               nw_data   = head_ok ? head_ff : NULL_LINK;
               pw_en     = head_ok;
               pw_addr   = head_addr;
               pw_data   = idx_link;
               new_head  = idx_link;
               new_count = count_ff + FREE_W'(1);
            end
         end
         CMD_ALLOC: begin
            if (head_ok) begin
               status    = ST_OK;
               granted   = FRAME_W'(head_ff);
               pw_en     = n_ok;
               pw_addr   = AW'(next_rd_ff);
               pw_data   = NULL_LINK;
               fw_en     = 1'b1;
               fw_addr   = head_addr;
               new_head  = n_val;
               new_count = count_ff - FREE_W'(1);
            end else begin
               status  = ST_EMPTY;
               granted = '0;
            end
         end
         CMD_CLAIM: begin
            if (idx_ok_ff && free_rd_ff) begin
               status  = ST_OK;
               pw_en   = n_ok;
               pw_addr = AW'(next_rd_ff);
               pw_data = p_val;
               if (p_ok) begin
                  nw_en   = 1'b1;
                  nw_addr = AW'(p_val);
                  nw_data = n_val;
               end else begin
                  new_head = n_val;
               end
               fw_en     = 1'b1;
               new_count = count_ff - FREE_W'(1);
            end
         end
         default: begin
            status = ST_WRONG;
         end
      endcase
   end

   // write ports
   always_ff @(posedge clock) begin
      if (commit && nw_en) begin
         next_mem[nw_addr] <= nw_data;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && pw_en) begin
         prev_mem[pw_addr] <= pw_data;
      end
   end

   // free flags: swept clear after reset, then written back by each successful command
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         free_mem[clr_ff] <= 1'b0;
      end else if (commit && fw_en) begin
         free_mem[fw_addr] <= fw_data;
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      idx_ok_in    = idx_ok_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_FRAME) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_chan.data.cmd;
               idx_in    = req_chan.data.frame_index;
               idx_ok_in = 32'(req_chan.data.frame_index) < NUM_FRAMES;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               head_in                  = new_head;
               count_in                 = new_count;
               rsp_valid_in             = 1'b1;
               rsp_data_in.granted_frame = granted;
               rsp_data_in.status       = status;
               rsp_data_in.free_frames  = new_count;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= NULL_LINK;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      idx_ok_ff   <= idx_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire
